// ===== design/totp_pkg.sv =====
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types, constants and SHA-1 round helpers for the TOTP verifier.
// ----------------------------------------------------------------------------
package totp_pkg;

  // sha-1 geometry
  localparam int WordBits   = 32;
  localparam int BlockWords = 16;
  localparam int Rounds     = 80;
  localparam int RoundBits  = $clog2(Rounds);

  // totp constants
  localparam int unsigned StepSeconds = 30;
  localparam int unsigned CodeModulus = 1000000;
  localparam logic [31:0] TruncMask   = 32'h7fff_ffff;
  localparam logic [3:0]  OffsetMask  = 4'hf;

  // reciprocal of the step length, ceil(2^26 / 30), exact for 21-bit digits
  localparam int unsigned StepRecip = 2236963;
  localparam int          StepShift = 26;

  // configuration register indexes
  localparam logic [1:0] RegKeyHead   = 2'd0;
  localparam logic [1:0] RegKeyTail   = 2'd1;
  localparam logic [1:0] RegSkewLimit = 2'd2;

  // sha-1 initial chaining value
  localparam logic [159:0] Sha1Iv =
    160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

  // compression engine states
  typedef enum logic [1:0] {
    SHA_IDLE,
    SHA_RUN,
    SHA_DONE
  } sha_state_t;

  // verifier control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LAUNCH,
    ST_HASH,
    ST_MOD,
    ST_CHECK,
    ST_DONE
  } ctl_state_t;

  // round function by round number
  function automatic logic [31:0] sha1_f(input logic [RoundBits-1:0] r,
                                         input logic [31:0] b,
                                         input logic [31:0] c,
                                         input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // round constant by round number
  function automatic logic [31:0] sha1_k(input logic [RoundBits-1:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5a827999;
    end else if (r < 7'd40) begin
      k = 32'h6ed9eba1;
    end else if (r < 7'd60) begin
      k = 32'h8f1bbcdc;
    end else begin
      k = 32'hca62c1d6;
    end
    return k;
  endfunction

endpackage

// ===== design/totp_wcell.sv =====
// ----------------------------------------------------------------------------
// totp_wcell
// One word of the SHA-1 message schedule window; loads or takes its neighbor.
// ----------------------------------------------------------------------------
module totp_wcell
  import totp_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [WordBits-1:0] load_word,
  input  logic                shift,
  input  logic [WordBits-1:0] shift_in,
  output logic [WordBits-1:0] word
);

  // word register
  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end else if (shift) begin
      word <= shift_in;
    end
  end

endmodule

// ===== design/totp_sha1_core.sv =====
// ----------------------------------------------------------------------------
// totp_sha1_core
// SHA-1 compression of one block, one round per cycle over a chain of
// sixteen schedule cells.
// ----------------------------------------------------------------------------
module totp_sha1_core
  import totp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [511:0]   block,
  input  logic [159:0]   h_in,
  output logic           done,
  output logic [159:0]   h_out
);

  sha_state_t           state, state_next;
  logic [RoundBits-1:0] round;
  logic [31:0]          a, b, c, d, e;
  logic [159:0]         h_save;
  logic [31:0]          w_out [BlockWords];
  logic [31:0]          w_in  [BlockWords];
  logic [31:0]          w_new;
  logic [31:0]          t_sum;
  logic                 load, shift;

  // schedule extension and round sum
  assign w_new = {w_out[13][30:0] ^ w_out[8][30:0] ^ w_out[2][30:0] ^ w_out[0][30:0],
                  w_out[13][31] ^ w_out[8][31] ^ w_out[2][31] ^ w_out[0][31]};
  assign t_sum = {a[26:0], a[31:27]} + sha1_f(round, b, c, d) + e
               + sha1_k(round) + w_out[0];

  // schedule cell chain
  for (genvar j = 0; j < BlockWords; j++) begin : g_cell
    if (j == BlockWords - 1) begin : g_tail
      assign w_in[j] = w_new;
    end else begin : g_mid
      assign w_in[j] = w_out[j+1];
    end
    totp_wcell u_cell (
      .clk       (clk),
      .load      (load),
      .load_word (block[511 - 32*j -: 32]),
      .shift     (shift),
      .shift_in  (w_in[j]),
      .word      (w_out[j])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SHA_IDLE: if (start) state_next = SHA_RUN;
      SHA_RUN:  if (round == RoundBits'(Rounds - 1)) state_next = SHA_DONE;
      SHA_DONE: state_next = SHA_IDLE;
      default:  state_next = SHA_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load  = (state == SHA_IDLE) && start;
    shift = (state == SHA_RUN);
    done  = (state == SHA_DONE);
  end

  assign h_out = {h_save[159:128] + a, h_save[127:96] + b, h_save[95:64] + c,
                  h_save[63:32] + d, h_save[31:0] + e};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SHA_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (load) begin
      {a, b, c, d, e} <= h_in;
      h_save          <= h_in;
      round           <= '0;
    end else if (shift) begin
      a     <= t_sum;
      b     <= a;
      c     <= {b[1:0], b[31:2]};
      d     <= c;
      e     <= d;
      round <= round + 1'b1;
    end
  end

endmodule

// ===== design/totp_code_verifier_unit.sv =====
// ----------------------------------------------------------------------------
// totp_code_verifier_unit
// TOTP (HMAC-SHA1, 30 s step) verifier with a skew window.
// ----------------------------------------------------------------------------
// One item takes a Unix time and a six-digit code and yields one result. The
// time is divided by 30 sixteen bits a cycle by reciprocal multiplication.
// Each tried step then runs four SHA-1 compressions on the single
// round-per-cycle engine and a reduction modulo 1000000 by conditional
// subtraction plus one compare. Tries are 1 + 2 * skew limit, fewer when a
// code matches early.
// An input holding register takes the next item while one is at work, and an
// output register keeps a finished result until it is taken.
// ----------------------------------------------------------------------------
module totp_code_verifier_unit
  import totp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] time_seconds,
  input  logic [19:0] entered_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        code_valid,
  output logic signed [3:0] step_offset,
  output logic [19:0] expected_code
);

  ctl_state_t   state, state_next;
  logic [63:0]  key_head;
  logic [15:0]  key_tail;
  logic [2:0]   skew_limit;
  logic         hold_full;
  logic [63:0]  hold_time;
  logic [19:0]  hold_code;
  logic [63:0]  time_sh;
  logic [4:0]   rem;
  logic [31:0]  quo;
  logic [1:0]   dig_cnt;
  logic [19:0]  entered;
  logic [2:0]   skew;
  logic         neg;
  logic [1:0]   phase;
  logic [159:0] chain, inner;
  logic [30:0]  mod_val;
  logic [3:0]   mod_k;
  logic [19:0]  now_code;
  logic         res_match;
  logic [3:0]   res_off;
  logic         take;
  logic         sha_start, sha_done;
  logic [511:0] sha_block;
  logic [159:0] sha_h_in, sha_h_out;
  logic [31:0]  try_ctr;
  logic [20:0]  dig_val;
  logic [42:0]  dig_prod;
  logic [15:0]  dig_quo;
  logic [4:0]   dig_rem;
  logic [7:0]   trunc_base;
  logic [31:0]  trunc_word;
  logic [30:0]  mod_base;
  logic         code_hit;
  logic         last_try;
  logic         out_free;

  // handshakes
  assign in_ready = !hold_full;
  assign take     = (state == ST_IDLE) && hold_full;
  assign out_free = !out_valid || out_ready;

  // one 16-bit digit of the division by the step length
  assign dig_val  = {rem, time_sh[63:48]};
  assign dig_prod = {22'd0, dig_val} * 43'(StepRecip);
  assign dig_quo  = dig_prod[StepShift +: 16];
  assign dig_rem  = 5'(dig_val - {5'd0, dig_quo} * 21'(StepSeconds));

  // counter of the current try
  assign try_ctr = neg ? quo - {29'd0, skew} : quo + {29'd0, skew};

  // block for the current phase of hmac
  always_comb begin
    case (phase)
      2'd0:    sha_block = {key_head ^ {8{8'h36}}, key_tail ^ 16'h3636, {54{8'h36}}};
      2'd1:    sha_block = {32'd0, try_ctr, 8'h80, 376'd0, 64'd576};
      2'd2:    sha_block = {key_head ^ {8{8'h5c}}, key_tail ^ 16'h5c5c, {54{8'h5c}}};
      default: sha_block = {inner, 8'h80, 280'd0, 64'd672};
    endcase
  end
  assign sha_h_in = phase[0] ? chain : Sha1Iv;

  // dynamic truncation of the final digest
  assign trunc_base = 8'd159 - {1'b0, sha_h_out[3:0] & OffsetMask, 3'b000};
  assign trunc_word = sha_h_out[trunc_base -: 32] & TruncMask;

  // modulo reduction and compare
  assign mod_base = 31'(CodeModulus) << mod_k;
  assign code_hit = (mod_val[19:0] == entered) && (mod_val[30:20] == '0);
  assign last_try = (skew == skew_limit) && (neg || (skew == 3'd0));

  totp_sha1_core u_sha (
    .clk   (clk),
    .rst   (rst),
    .start (sha_start),
    .block (sha_block),
    .h_in  (sha_h_in),
    .done  (sha_done),
    .h_out (sha_h_out)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (hold_full) state_next = ST_DIV;
      ST_DIV:    if (dig_cnt == 2'd3) state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_HASH;
      ST_HASH:   if (sha_done) state_next = (phase == 2'd3) ? ST_MOD : ST_LAUNCH;
      ST_MOD:    if (mod_k == 4'd0) state_next = ST_CHECK;
      ST_CHECK:  state_next = (code_hit || last_try) ? ST_DONE : ST_LAUNCH;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs to the engine
  always_comb begin
    sha_start = (state == ST_LAUNCH);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_full  <= 1'b0;
      out_valid  <= 1'b0;
      key_head   <= '0;
      key_tail   <= '0;
      skew_limit <= 3'd1;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        hold_full <= 1'b1;
      end else if (take) begin
        hold_full <= 1'b0;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          RegKeyHead:   key_head   <= cfg_data;
          RegKeyTail:   key_tail   <= cfg_data[15:0];
          RegSkewLimit: skew_limit <= cfg_data[2:0];
          default:      ;
        endcase
      end
    end
  end

  // input holding register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_time <= time_seconds;
      hold_code <= entered_code;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (take) begin
      time_sh <= hold_time;
      entered <= hold_code;
      rem     <= '0;
      dig_cnt <= '0;
      skew    <= '0;
      neg     <= 1'b0;
      phase   <= '0;
    end
    if (state == ST_DIV) begin
      rem     <= dig_rem;
      quo     <= {quo[15:0], dig_quo};
      time_sh <= {time_sh[47:0], 16'd0};
      dig_cnt <= dig_cnt + 1'b1;
    end
    if (state == ST_HASH && sha_done) begin
      phase <= phase + 1'b1;
      case (phase)
        2'd1:    inner <= sha_h_out;
        2'd3:    begin
          mod_val <= trunc_word[30:0];
          mod_k   <= 4'd11;
        end
        default: chain <= sha_h_out;
      endcase
    end
    if (state == ST_MOD) begin
      if (mod_val >= mod_base) begin
        mod_val <= mod_val - mod_base;
      end
      mod_k <= mod_k - 1'b1;
    end
    if (state == ST_CHECK) begin
      if (skew == 3'd0) begin
        now_code <= mod_val[19:0];
      end
      res_match <= code_hit;
      res_off   <= code_hit ? (neg ? 4'(-{1'b0, skew}) : {1'b0, skew}) : 4'd0;
      if (!neg && skew != 3'd0) begin
        neg <= 1'b1;
      end else begin
        neg  <= 1'b0;
        skew <= skew + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      code_valid    <= res_match;
      step_offset   <= res_off;
      expected_code <= now_code;
    end
  end

  // engine only finishes while the controller waits for it
  assert property (@(posedge clk) disable iff (rst)
    sha_done |-> state == ST_HASH)
    else $error("hash engine finished outside hash wait");

  // a reduced code is always below the modulus
  assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> mod_val < 31'(CodeModulus))
    else $error("code reduction incomplete");

  // a miss reports offset zero
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !res_match) |-> res_off == 4'd0)
    else $error("offset reported without a match");

  // tries never run past the skew window
  assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> skew <= skew_limit)
    else $error("try beyond skew window");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TOTP code verifier. A scoreboard class models
// HMAC-SHA1 HOTP and the skew window search for every accepted item and
// compares each result in order. Stimulus covers counter wrap, out-of-range
// codes, matches at every window offset and several key and skew settings,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb
  import totp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 4000000;
  localparam int HoldCycles = 20000;
  localparam int DrainCycles = 64;

  typedef struct packed {
    logic              code_valid;
    logic signed [3:0] step_offset;
    logic [19:0]       expected_code;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // scoreboard: hotp model plus queue of pending verdicts
  // ---------------------------------------------------------------------------
  class totp_scoreboard;
    logic [63:0] key_head;
    logic [15:0] key_tail;
    logic [2:0]  skew_limit;
    verdict_t    pending[$];
    int          errors;

    function new();
      key_head   = '0;
      key_tail   = '0;
      skew_limit = 3'd1;
      errors     = 0;
    endfunction

    static function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    static function logic [159:0] compress(logic [159:0] h, logic [511:0] blk);
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      {a, b, c, d, e} = h;
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = 32'h5a827999;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = 32'h6ed9eba1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
        end else begin
          f = b ^ c ^ d; k = 32'hca62c1d6;
        end
        t = rotl(a, 5) + f + e + k + w[i];
        e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    static function logic [19:0] hotp(logic [79:0] key, logic [31:0] ctr);
      logic [511:0] pad;
      logic [159:0] h, inner, mac;
      logic [31:0]  bin, code;
      int           off;
      pad   = {key, 432'b0} ^ {64{8'h36}};
      h     = compress(Sha1Iv, pad);
      inner = compress(h, {32'h0, ctr, 8'h80, 376'b0, 64'd576});
      pad   = {key, 432'b0} ^ {64{8'h5c}};
      h     = compress(Sha1Iv, pad);
      mac   = compress(h, {inner, 8'h80, 280'b0, 64'd672});
      off   = int'(mac[3:0] & OffsetMask);
      bin   = mac[159 - 8 * off -: 32];
      code  = (bin & TruncMask) % CodeModulus;
      return code[19:0];
    endfunction

    function logic [31:0] step_of(logic [63:0] t);
      logic [63:0] q;
      q = t / 64'(StepSeconds);
      return q[31:0];
    endfunction

    // code of the step k away from the item's own step
    function logic [19:0] code_at(logic [63:0] t, int k);
      return hotp({key_head, key_tail}, step_of(t) + 32'(k));
    endfunction

    function void note_item(logic [63:0] t, logic [19:0] entered);
      verdict_t    v;
      logic [31:0] ctr;
      ctr = step_of(t);
      v.code_valid    = 1'b0;
      v.step_offset   = '0;
      v.expected_code = hotp({key_head, key_tail}, ctr);
      // try order +0, -0, +1, -1, ...; first hit wins
      for (int s = 0; s <= int'(skew_limit); s++) begin
        if ((s == 0 ? v.expected_code : hotp({key_head, key_tail}, ctr + 32'(s))) == entered)
        begin
          v.code_valid = 1'b1; v.step_offset = 4'(s); break;
        end
        if ((s == 0 ? v.expected_code : hotp({key_head, key_tail}, ctr - 32'(s))) == entered)
        begin
          v.code_valid = 1'b1; v.step_offset = 4'(-s); break;
        end
      end
      pending.push_back(v);
    endfunction

    function void check_result(logic cv, logic signed [3:0] off, logic [19:0] code);
      verdict_t v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result valid=%0d offset=%0d code=%0d",
                 $time, cv, off, code);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (cv !== v.code_valid) begin
        $display("%0t: code_valid expected %0d actual %0d", $time, v.code_valid, cv);
        errors++;
      end
      if (off !== v.step_offset) begin
        $display("%0t: step_offset expected %0d actual %0d", $time, v.step_offset, off);
        errors++;
      end
      if (code !== v.expected_code) begin
        $display("%0t: expected_code expected %0d actual %0d",
                 $time, v.expected_code, code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] time_seconds = '0;
  logic [19:0] entered_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic code_valid;
  logic signed [3:0] step_offset;
  logic [19:0] expected_code;

  totp_scoreboard sb = new();
  bit hold_req = 1'b0;
  bit quiet = 1'b0;
  int cycles = 0;

  totp_code_verifier_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .time_seconds(time_seconds), .entered_code(entered_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_valid(code_valid), .step_offset(step_offset), .expected_code(expected_code)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // result monitor: outputs are stable at the falling edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(code_valid, step_offset, expected_code);
  end

  // output side: random ready stretches, one long hold-off on request
  initial begin
    int run;
    bit rdy;
    run = 0;
    rdy = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        if (run == 0) begin
          run = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 8);
          rdy = ($urandom_range(0, 3) != 0);
        end
        run--;
        out_ready <= rdy;
      end
    end
  end

  // offer one item, return at the edge that takes it
  task automatic send_item(logic [63:0] t, logic [19:0] code);
    in_valid     <= 1'b1;
    time_seconds <= t;
    entered_code <= code;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_item(t, code);
  endtask

  // idle gap after an item: mostly short, a few long
  task automatic input_gap();
    int gap;
    gap = quiet ? 0 :
          (($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for all results, then set the registers
  task automatic set_config(logic [63:0] head, logic [15:0] tail, logic [2:0] skew);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= RegKeyHead; cfg_data <= head;
    @(posedge clk);
    cfg_index <= RegKeyTail; cfg_data <= {48'b0, tail};
    @(posedge clk);
    cfg_index <= RegSkewLimit; cfg_data <= {61'b0, skew};
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.key_head   = head;
    sb.key_tail   = tail;
    sb.skew_limit = skew;
    @(posedge clk);
  endtask

  localparam logic [63:0] WrapLow  = 64'h0000_0000_ffff_ffff * 30;
  localparam logic [63:0] WrapHigh = 64'h0000_0001_0000_0000 * 30;
  localparam logic [63:0] TimeMax  = 64'hffff_ffff_ffff_ffff;

  initial begin
    int skews[9]  = '{0, 1, 0, 2, 1, 0, 3, 0, 7};
    int counts[9] = '{80, 70, 80, 60, 70, 80, 50, 80, 12};
    logic [63:0] t;
    logic [19:0] code;
    int sel, k, sk;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero key, skew 1, step wraps below zero and at the top
    send_item(64'd0, sb.code_at(64'd0, -1));       input_gap();
    send_item(TimeMax, sb.code_at(TimeMax, 1));     input_gap();
    send_item(64'd29, 20'd0);                       input_gap();

    // ascii key, skew 1
    set_config(64'h3132_3334_3536_3738, 16'h3930, 3'd1);
    send_item(64'd59, sb.code_at(64'd59, 0));                 input_gap();
    send_item(WrapLow + 15, sb.code_at(WrapLow + 15, 1));     input_gap();
    send_item(WrapHigh + 3, sb.code_at(WrapHigh + 3, -1));    input_gap();
    send_item(64'd0, sb.code_at(64'd0, -1));                  input_gap();
    send_item(TimeMax, 20'hfffff);                            input_gap();
    send_item(64'd1234567890, 20'd999999);                    input_gap();
    send_item(64'd1234567890, 20'd1000000);                   input_gap();
    send_item(64'd1234567890, 20'd0);                         input_gap();
    send_item(64'd1111111109, sb.code_at(64'd1111111109, -1)); input_gap();
    send_item(64'd1111111109, sb.code_at(64'd1111111109, 1));  input_gap();
    send_item(64'd1111111109, sb.code_at(64'd1111111109, 2));  input_gap();

    // no skew: only the current step matches
    set_config(64'h0, 16'h0, 3'd0);
    send_item(64'd20000000000, sb.code_at(64'd20000000000, 1)); input_gap();
    send_item(64'd20000000000, sb.code_at(64'd20000000000, 0)); input_gap();
    send_item(WrapLow, sb.code_at(WrapLow, -1));                input_gap();

    // all-ones key, widest window
    set_config(TimeMax, 16'hffff, 3'd7);
    send_item(64'd987654321, sb.code_at(64'd987654321, 7));  input_gap();
    send_item(64'd987654321, sb.code_at(64'd987654321, -7)); input_gap();
    send_item(64'd987654321, sb.code_at(64'd987654321, 8));  input_gap();
    send_item(WrapHigh, sb.code_at(WrapHigh, -5));           input_gap();

    // random phases
    for (int p = 0; p < 9; p++) begin
      set_config({$urandom, $urandom}, 16'($urandom), 3'(skews[p]));
      quiet = (p == 4);
      if (p == 2) hold_req = 1'b1;
      sk = skews[p];
      for (int n = 0; n < counts[p]; n++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) t = 64'($urandom_range(0, 200));
        else if (sel == 1) t = WrapLow + 64'($urandom_range(0, 89));
        else if (sel == 2) t = WrapHigh - 64'($urandom_range(0, 89));
        else t = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel <= 3) begin
          k = int'($urandom_range(0, 2 * sk)) - sk;
          code = sb.code_at(t, k);
        end else if (sel == 4) begin
          code = sb.code_at(t, ($urandom_range(0, 1) != 0) ? sk + 1 : -(sk + 1));
        end else if (sel == 5) begin
          code = 20'($urandom_range(1000000, 1048575));
        end else begin
          code = 20'($urandom);
        end
        send_item(t, code);
        input_gap();
      end
      quiet = 1'b0;
    end

    // drain
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
